FILE: rtl/core/kana_text_normalizer_assert.svh
// assertion macros shared by the kana normalizer modules
`ifndef KANA_TEXT_NORMALIZER_ASSERT_SVH
`define KANA_TEXT_NORMALIZER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define KTN_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("ktn assertion failed");

// next-cycle implication, checked outside reset
`define KTN_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("ktn assertion failed");

`endif

FILE: rtl/core/ktn_pkg.sv
// ----------------------------------------------------------------------------
// ktn_pkg
// types, code point constants and kana lookup tables for the kana normalizer
// ----------------------------------------------------------------------------
`default_nettype none

package ktn_pkg;

    localparam int CP_W  = 21;
    localparam int IDX_W = 12;

    // result queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    localparam logic [CP_W-1:0] HALF_KANA_LO = 21'h0FF66;
    localparam logic [CP_W-1:0] HALF_KANA_HI = 21'h0FF9D;
    localparam logic [CP_W-1:0] HALF_VOICED  = 21'h0FF9E;
    localparam logic [CP_W-1:0] HALF_SEMI    = 21'h0FF9F;
    localparam logic [CP_W-1:0] HALF_STOP    = 21'h0FF61;
    localparam logic [CP_W-1:0] HALF_COMMA   = 21'h0FF64;
    localparam logic [CP_W-1:0] HALF_MIDDOT  = 21'h0FF65;
    localparam logic [CP_W-1:0] FULL_STOP    = 21'h03002;
    localparam logic [CP_W-1:0] FULL_COMMA   = 21'h03001;
    localparam logic [CP_W-1:0] FULL_MIDDOT  = 21'h030FB;
    localparam logic [CP_W-1:0] MARK_VOICED  = 21'h03099;
    localparam logic [CP_W-1:0] MARK_SEMI    = 21'h0309A;
    localparam logic [CP_W-1:0] KATA_LO      = 21'h030A1;
    localparam logic [CP_W-1:0] KATA_HI      = 21'h030F6;
    localparam logic [CP_W-1:0] KATA_SHIFT   = 21'h00060;

    typedef struct packed {
        logic [CP_W-1:0]  cp;
        logic [IDX_W-1:0] idx;
        logic             last;
    } ktn_res_t;

    typedef struct packed {
        logic [1:0] n;
        ktn_res_t   res0;
        ktn_res_t   res1;
    } ktn_push_t;

    typedef struct packed {
        logic        hit;
        logic [15:0] form;
    } ktn_merge_t;

    function automatic logic [15:0] half_kana(input logic [5:0] i);
        logic [15:0] r;
        case (i)
            6'd0:  r = 16'h30F2;  6'd1:  r = 16'h30A1;  6'd2:  r = 16'h30A3;
            6'd3:  r = 16'h30A5;  6'd4:  r = 16'h30A7;  6'd5:  r = 16'h30A9;
            6'd6:  r = 16'h30E3;  6'd7:  r = 16'h30E5;  6'd8:  r = 16'h30E7;
            6'd9:  r = 16'h30C3;  6'd10: r = 16'h30FC;  6'd11: r = 16'h30A2;
            6'd12: r = 16'h30A4;  6'd13: r = 16'h30A6;  6'd14: r = 16'h30A8;
            6'd15: r = 16'h30AA;  6'd16: r = 16'h30AB;  6'd17: r = 16'h30AD;
            6'd18: r = 16'h30AF;  6'd19: r = 16'h30B1;  6'd20: r = 16'h30B3;
            6'd21: r = 16'h30B5;  6'd22: r = 16'h30B7;  6'd23: r = 16'h30B9;
            6'd24: r = 16'h30BB;  6'd25: r = 16'h30BD;  6'd26: r = 16'h30BF;
            6'd27: r = 16'h30C1;  6'd28: r = 16'h30C4;  6'd29: r = 16'h30C6;
            6'd30: r = 16'h30C8;  6'd31: r = 16'h30CA;  6'd32: r = 16'h30CB;
            6'd33: r = 16'h30CC;  6'd34: r = 16'h30CD;  6'd35: r = 16'h30CE;
            6'd36: r = 16'h30CF;  6'd37: r = 16'h30D2;  6'd38: r = 16'h30D5;
            6'd39: r = 16'h30D8;  6'd40: r = 16'h30DB;  6'd41: r = 16'h30DE;
            6'd42: r = 16'h30DF;  6'd43: r = 16'h30E0;  6'd44: r = 16'h30E1;
            6'd45: r = 16'h30E2;  6'd46: r = 16'h30E4;  6'd47: r = 16'h30E6;
            6'd48: r = 16'h30E8;  6'd49: r = 16'h30E9;  6'd50: r = 16'h30EA;
            6'd51: r = 16'h30EB;  6'd52: r = 16'h30EC;  6'd53: r = 16'h30ED;
            6'd54: r = 16'h30EF;  6'd55: r = 16'h30F3;
            default: r = 16'h0000;
        endcase
        return r;
    endfunction

    function automatic ktn_merge_t voiced_of(input logic [15:0] b);
        ktn_merge_t r;
        r.hit = 1'b1;
        case (b)
            16'h304B: r.form = 16'h304C;  16'h304D: r.form = 16'h304E;
            16'h304F: r.form = 16'h3050;  16'h3051: r.form = 16'h3052;
            16'h3053: r.form = 16'h3054;  16'h3055: r.form = 16'h3056;
            16'h3057: r.form = 16'h3058;  16'h3059: r.form = 16'h305A;
            16'h305B: r.form = 16'h305C;  16'h305D: r.form = 16'h305E;
            16'h305F: r.form = 16'h3060;  16'h3061: r.form = 16'h3062;
            16'h3064: r.form = 16'h3065;  16'h3066: r.form = 16'h3067;
            16'h3068: r.form = 16'h3069;  16'h306F: r.form = 16'h3070;
            16'h3072: r.form = 16'h3073;  16'h3075: r.form = 16'h3076;
            16'h3078: r.form = 16'h3079;  16'h307B: r.form = 16'h307C;
            16'h3046: r.form = 16'h3094;
            default: begin
                r.hit  = 1'b0;
                r.form = 16'h0000;
            end
        endcase
        return r;
    endfunction

    function automatic ktn_merge_t semi_of(input logic [15:0] b);
        ktn_merge_t r;
        r.hit = 1'b1;
        case (b)
            16'h306F: r.form = 16'h3071;
            16'h3072: r.form = 16'h3074;
            16'h3075: r.form = 16'h3077;
            16'h3078: r.form = 16'h307A;
            16'h307B: r.form = 16'h307D;
            default: begin
                r.hit  = 1'b0;
                r.form = 16'h0000;
            end
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/ktn_front.sv
// ----------------------------------------------------------------------------
// ktn_front
// accepts code points, maps them, merges marks into the held character and
// pushes zero to two finished results into the queue
// ----------------------------------------------------------------------------
`default_nettype none

`include "kana_text_normalizer_assert.svh"

module ktn_front #(
    parameter int MAX_TEXT = 4096
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    s_tvalid,
    output logic                         s_tready,
    input  wire logic [ktn_pkg::CP_W-1:0] s_cp,
    input  wire logic                    s_last,
    input  wire logic                    q_room,
    output ktn_pkg::ktn_push_t           push
);

    localparam int CNT_W = (MAX_TEXT > 2) ? $clog2(MAX_TEXT) : 1;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_TEXT - 1);

    logic [ktn_pkg::CP_W-1:0]  held_char_reg, held_char_next;
    logic [ktn_pkg::IDX_W-1:0] held_index_reg, held_index_next;
    logic                      held_valid_reg, held_valid_next;
    logic [CNT_W-1:0]          pos_reg, pos_next;

    logic                      accept;
    logic [ktn_pkg::CP_W-1:0]  half_off;
    logic [ktn_pkg::CP_W-1:0]  c_half;
    logic [ktn_pkg::CP_W-1:0]  c_map;
    logic [CNT_W+ktn_pkg::IDX_W-1:0] pos_ext;
    logic [ktn_pkg::IDX_W-1:0] idx_now;
    ktn_pkg::ktn_merge_t       lk;
    logic                      is_mark;
    logic                      merge;
    logic                      emit_held;
    logic [ktn_pkg::CP_W-1:0]  new_char;
    logic [ktn_pkg::IDX_W-1:0] new_idx;
    ktn_pkg::ktn_res_t         res_held;
    ktn_pkg::ktn_res_t         res_end;

    assign s_tready = q_room;
    assign accept   = s_tvalid && s_tready;

    // halfwidth forms first, then katakana folds down to hiragana
    always_comb begin
        half_off = s_cp - ktn_pkg::HALF_KANA_LO;
        if (s_cp >= ktn_pkg::HALF_KANA_LO && s_cp <= ktn_pkg::HALF_KANA_HI) begin
            c_half = {5'b0, ktn_pkg::half_kana(half_off[5:0])};
        end else if (s_cp == ktn_pkg::HALF_VOICED) begin
            c_half = ktn_pkg::MARK_VOICED;
        end else if (s_cp == ktn_pkg::HALF_SEMI) begin
            c_half = ktn_pkg::MARK_SEMI;
        end else if (s_cp == ktn_pkg::HALF_STOP) begin
            c_half = ktn_pkg::FULL_STOP;
        end else if (s_cp == ktn_pkg::HALF_COMMA) begin
            c_half = ktn_pkg::FULL_COMMA;
        end else if (s_cp == ktn_pkg::HALF_MIDDOT) begin
            c_half = ktn_pkg::FULL_MIDDOT;
        end else begin
            c_half = s_cp;
        end
        if (c_half >= ktn_pkg::KATA_LO && c_half <= ktn_pkg::KATA_HI) begin
            c_map = c_half - ktn_pkg::KATA_SHIFT;
        end else begin
            c_map = c_half;
        end
    end

    assign pos_ext = {{ktn_pkg::IDX_W{1'b0}}, pos_reg};
    assign idx_now = pos_ext[ktn_pkg::IDX_W-1:0];

    always_comb begin
        is_mark = (c_map == ktn_pkg::MARK_VOICED) || (c_map == ktn_pkg::MARK_SEMI);
        if (c_map == ktn_pkg::MARK_VOICED) begin
            lk = ktn_pkg::voiced_of(held_char_reg[15:0]);
        end else begin
            lk = ktn_pkg::semi_of(held_char_reg[15:0]);
        end
        merge = held_valid_reg && is_mark && lk.hit && (held_char_reg[20:16] == 5'b0);
        emit_held = held_valid_reg && !merge;
        new_char  = merge ? {5'b0, lk.form} : c_map;
        new_idx   = merge ? held_index_reg : idx_now;

        res_held.cp   = held_char_reg;
        res_held.idx  = held_index_reg;
        res_held.last = 1'b0;
        res_end.cp    = new_char;
        res_end.idx   = new_idx;
        res_end.last  = 1'b1;

        push.res0 = emit_held ? res_held : res_end;
        push.res1 = res_end;
        push.n    = accept ? (2'(emit_held) + 2'(s_last)) : 2'd0;
    end

    always_comb begin
        held_char_next  = held_char_reg;
        held_index_next = held_index_reg;
        held_valid_next = held_valid_reg;
        pos_next        = pos_reg;
        if (accept) begin
            held_char_next  = new_char;
            held_index_next = new_idx;
            held_valid_next = !s_last;
            if (s_last) begin
                pos_next = '0;
            end else if (pos_reg < CNT_MAX) begin
                pos_next = pos_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_valid_reg <= 1'b0;
            pos_reg        <= '0;
        end else begin
            held_valid_reg <= held_valid_next;
            pos_reg        <= pos_next;
        end
    end

    always_ff @(posedge aclk) begin
        held_char_reg  <= held_char_next;
        held_index_reg <= held_index_next;
    end

    `KTN_ASSERT_NEXT(a_eot_clears, aclk, aresetn, accept && s_last, !held_valid_reg && pos_reg == '0)
    `KTN_ASSERT_IMP(a_two_only_at_end, aclk, aresetn, push.n == 2'd2, s_last && held_valid_reg)
    `KTN_ASSERT_IMP(a_no_push_idle, aclk, aresetn, !accept, push.n == 2'd0)
    `KTN_ASSERT_IMP(a_pos_bound, aclk, aresetn, 1'b1, pos_reg <= CNT_MAX)

endmodule

`default_nettype wire

FILE: rtl/core/ktn_queue.sv
// ----------------------------------------------------------------------------
// ktn_queue
// short result queue, up to two writes and one read per cycle
// ----------------------------------------------------------------------------
`default_nettype none

`include "kana_text_normalizer_assert.svh"

module ktn_queue (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  ktn_pkg::ktn_push_t      push,
    output logic                    q_room,
    output logic                    q_valid,
    output ktn_pkg::ktn_res_t       q_head,
    input  wire logic               q_pop
);

    ktn_pkg::ktn_res_t                mem [ktn_pkg::QDEPTH];
    logic [ktn_pkg::QPTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [ktn_pkg::QPTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [ktn_pkg::QCNT_W-1:0]       count_reg, count_next;

    // room for a full end-of-text pair, whatever the back side does
    assign q_room  = count_reg <= ktn_pkg::QCNT_W'(ktn_pkg::QDEPTH - 2);
    assign q_valid = count_reg != '0;
    assign q_head  = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg + ktn_pkg::QPTR_W'(push.n);
        rd_ptr_next = q_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + ktn_pkg::QCNT_W'(push.n) - ktn_pkg::QCNT_W'(q_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.n != 2'd0) begin
            mem[wr_ptr_reg] <= push.res0;
        end
        if (push.n == 2'd2) begin
            mem[wr_ptr_reg + 1'b1] <= push.res1;
        end
    end

    `KTN_ASSERT_IMP(a_pop_nonempty, aclk, aresetn, q_pop, count_reg != '0)
    `KTN_ASSERT_IMP(a_push_fits, aclk, aresetn, push.n != 2'd0, q_room)
    `KTN_ASSERT_IMP(a_count_bound, aclk, aresetn, 1'b1, count_reg <= ktn_pkg::QCNT_W'(ktn_pkg::QDEPTH))
    `KTN_ASSERT_IMP(a_ptr_track, aclk, aresetn, 1'b1, ktn_pkg::QPTR_W'(count_reg) == wr_ptr_reg - rd_ptr_reg)

endmodule

`default_nettype wire

FILE: rtl/core/ktn_back.sv
// ----------------------------------------------------------------------------
// ktn_back
// pops results from the queue into the output register and drives the
// master side
// ----------------------------------------------------------------------------
`default_nettype none

module ktn_back (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          q_valid,
    input  ktn_pkg::ktn_res_t  q_head,
    output logic               q_pop,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [39:0]        m_tdata,
    output logic               m_tlast
);

    logic              out_valid_reg, out_valid_next;
    ktn_pkg::ktn_res_t out_reg, out_next;

    assign q_pop = q_valid && (!out_valid_reg || m_tready);

    always_comb begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (q_pop) begin
            out_next       = q_head;
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0, out_reg.idx, out_reg.cp};
    assign m_tlast  = out_reg.last;

endmodule

`default_nettype wire

FILE: rtl/core/kana_text_normalizer.sv
// ----------------------------------------------------------------------------
// kana_text_normalizer
// streaming kana normalizer: halfwidth to fullwidth, katakana to hiragana,
// voicing marks merged into the preceding kana
// ----------------------------------------------------------------------------
// One code point is accepted per cycle while the queue has room. Each
// character is held back until the next one arrives, so a beat gives zero or
// one result, and a beat with tlast gives up to two (the held character and
// the last one). Results leave at one beat per cycle while the receiver is
// ready, through an output register fed from a four-entry queue; the input
// takes a beat whenever the queue has two free entries, so a stream without
// stalls runs at one code point per cycle. A released result goes into the
// queue and then into the output register, and an end-of-text pair leaves as
// two output beats. Indexes count from zero per text and stop at MAX_TEXT-1.
`default_nettype none

module kana_text_normalizer #(
    parameter int MAX_TEXT = 4096
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // [20:0] code_point, [23:21] zero
    input  wire logic        s_tlast,   // end_of_text
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // [20:0] out_code_point, [32:21] source_index
    output logic             m_tlast    // last_of_text
);

    ktn_pkg::ktn_push_t push;
    ktn_pkg::ktn_res_t  q_head;
    logic               q_room;
    logic               q_valid;
    logic               q_pop;

    ktn_front #(
        .MAX_TEXT (MAX_TEXT)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_cp     (s_tdata[ktn_pkg::CP_W-1:0]),
        .s_last   (s_tlast),
        .q_room   (q_room),
        .push     (push)
    );

    ktn_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .q_room  (q_room),
        .q_valid (q_valid),
        .q_head  (q_head),
        .q_pop   (q_pop)
    );

    ktn_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

FILE: tb/sv/tb_kana_text_normalizer.sv
// ----------------------------------------------------------------------------
// tb_kana_text_normalizer
// self-checking stream testbench for the kana text normalizer
// ----------------------------------------------------------------------------
// Code points are sent as texts, and each text ends with an end-of-text beat.
// A behavioral model of the normalizer runs beside the block. It follows
// halfwidth folding, katakana to hiragana, voicing mark merges and the held
// character. Its expected characters wait in a queue, and every result beat
// is compared field by field. The sequence is a directed set of corner cases,
// one long text with wide indexes, a backpressure phase, and then
// random texts, most of them rich in base kana followed by voicing marks.
`default_nettype none

module tb_kana_text_normalizer;

    localparam int TEXT_MAX      = 4096;
    localparam int LONG_TEXT     = 300;
    localparam int RANDOM_BEATS  = 570;
    localparam int QUIET_TAIL    = 150;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;    // [20:0] code_point, [23:21] zero
    logic        s_tlast  = 1'b0;  // end_of_text
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;          // [20:0] out_code_point, [32:21] source_index
    logic        m_tlast;          // last_of_text

    kana_text_normalizer #(
        .MAX_TEXT(TEXT_MAX)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #2 aclk = ~aclk;

    // fullwidth katakana for halfwidth FF66..FF9D, in code order
    logic [15:0] half_to_full [0:55] = '{
        16'h30F2, 16'h30A1, 16'h30A3, 16'h30A5, 16'h30A7, 16'h30A9, 16'h30E3, 16'h30E5,
        16'h30E7, 16'h30C3, 16'h30FC, 16'h30A2, 16'h30A4, 16'h30A6, 16'h30A8, 16'h30AA,
        16'h30AB, 16'h30AD, 16'h30AF, 16'h30B1, 16'h30B3, 16'h30B5, 16'h30B7, 16'h30B9,
        16'h30BB, 16'h30BD, 16'h30BF, 16'h30C1, 16'h30C4, 16'h30C6, 16'h30C8, 16'h30CA,
        16'h30CB, 16'h30CC, 16'h30CD, 16'h30CE, 16'h30CF, 16'h30D2, 16'h30D5, 16'h30D8,
        16'h30DB, 16'h30DE, 16'h30DF, 16'h30E0, 16'h30E1, 16'h30E2, 16'h30E4, 16'h30E6,
        16'h30E8, 16'h30E9, 16'h30EA, 16'h30EB, 16'h30EC, 16'h30ED, 16'h30EF, 16'h30F3
    };

    // hiragana that take the voiced mark; all but u voice to the next code
    logic [15:0] voice_bases [0:20] = '{
        16'h304B, 16'h304D, 16'h304F, 16'h3051, 16'h3053, 16'h3055, 16'h3057,
        16'h3059, 16'h305B, 16'h305D, 16'h305F, 16'h3061, 16'h3064, 16'h3066,
        16'h3068, 16'h306F, 16'h3072, 16'h3075, 16'h3078, 16'h307B, 16'h3046
    };

    // ha row, semi-voiced form is two codes up
    logic [15:0] semi_bases [0:4] = '{16'h306F, 16'h3072, 16'h3075, 16'h3078, 16'h307B};

    ktn_pkg::ktn_res_t expected_chars [$];

    // normalizer state as the block should hold it
    logic [20:0] held_cp;
    logic [11:0] held_idx;
    bit          held_ok;
    int          text_pos;

    int  n_fail;
    int  n_beats;
    int  n_results;
    int  n_texts;
    int  n_merges;
    bit  src_idle_on;
    bit  sink_idle_on;
    int  sink_hold_req;

    initial begin
        held_cp       = '0;
        held_idx      = '0;
        held_ok       = 1'b0;
        text_pos      = 0;
        n_fail        = 0;
        n_beats       = 0;
        n_results     = 0;
        n_texts       = 0;
        n_merges      = 0;
        src_idle_on   = 1'b0;
        sink_idle_on  = 1'b0;
        sink_hold_req = 0;
    end

    function automatic logic [20:0] fold_code_point(input logic [20:0] raw);
        logic [20:0] c;
        c = raw;
        if (raw >= ktn_pkg::HALF_KANA_LO && raw <= ktn_pkg::HALF_KANA_HI)
            c = {5'd0, half_to_full[int'(raw - ktn_pkg::HALF_KANA_LO)]};
        else if (raw == ktn_pkg::HALF_VOICED)
            c = ktn_pkg::MARK_VOICED;
        else if (raw == ktn_pkg::HALF_SEMI)
            c = ktn_pkg::MARK_SEMI;
        else if (raw == ktn_pkg::HALF_STOP)
            c = ktn_pkg::FULL_STOP;
        else if (raw == ktn_pkg::HALF_COMMA)
            c = ktn_pkg::FULL_COMMA;
        else if (raw == ktn_pkg::HALF_MIDDOT)
            c = ktn_pkg::FULL_MIDDOT;
        if (c >= ktn_pkg::KATA_LO && c <= ktn_pkg::KATA_HI)
            c = c - ktn_pkg::KATA_SHIFT;
        return c;
    endfunction

    function automatic bit merge_voicing(input logic [20:0] base, input logic [20:0] mark,
                                         output logic [20:0] merged);
        int i;
        merged = base;
        if (mark == ktn_pkg::MARK_VOICED) begin
            for (i = 0; i < 21; i++) begin
                if ({5'd0, voice_bases[i]} == base) begin
                    merged = (base == 21'h03046) ? 21'h03094 : base + 21'd1;
                    return 1'b1;
                end
            end
        end else begin
            for (i = 0; i < 5; i++) begin
                if ({5'd0, semi_bases[i]} == base) begin
                    merged = base + 21'd2;
                    return 1'b1;
                end
            end
        end
        return 1'b0;
    endfunction

    function automatic ktn_pkg::ktn_res_t make_char(input logic [20:0] cp,
                                                    input logic [11:0] idx, input bit last);
        ktn_pkg::ktn_res_t r;
        r.cp   = cp;
        r.idx  = idx;
        r.last = last;
        return r;
    endfunction

    task automatic add_expected(input ktn_pkg::ktn_res_t r);
        expected_chars = {expected_chars, r};
    endtask

    task automatic normalize_beat(input logic [20:0] raw, input bit eot);
        logic [20:0] c;
        logic [20:0] merged;
        logic [11:0] idx;
        bit          hit;
        c   = fold_code_point(raw);
        idx = text_pos[11:0];
        hit = 1'b0;
        if (text_pos < TEXT_MAX - 1)
            text_pos++;
        if (held_ok && (c == ktn_pkg::MARK_VOICED || c == ktn_pkg::MARK_SEMI))
            hit = merge_voicing(held_cp, c, merged);
        if (hit) begin
            held_cp = merged;
            n_merges++;
        end else begin
            if (held_ok)
                add_expected(make_char(held_cp, held_idx, 1'b0));
            held_cp  = c;
            held_idx = idx;
            held_ok  = 1'b1;
        end
        if (eot) begin
            add_expected(make_char(held_cp, held_idx, 1'b1));
            held_ok  = 1'b0;
            text_pos = 0;
            n_texts++;
        end
    endtask

    // inputs and outputs are both taken as they stood before the edge
    always @(posedge aclk) begin
        ktn_pkg::ktn_res_t want;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                normalize_beat(s_tdata[20:0], s_tlast);
                n_beats++;
            end
            if (m_tvalid && m_tready) begin
                n_results++;
                if (expected_chars.size() == 0) begin
                    $error("unexpected result beat: out_code_point %h source_index %0d last %b",
                           m_tdata[20:0], m_tdata[32:21], m_tlast);
                    n_fail++;
                end else begin
                    want = expected_chars.pop_front();
                    if (m_tdata[20:0] !== want.cp) begin
                        $error("out_code_point: expected %h, got %h", want.cp, m_tdata[20:0]);
                        n_fail++;
                    end
                    if (m_tdata[32:21] !== want.idx) begin
                        $error("source_index: expected %0d, got %0d", want.idx, m_tdata[32:21]);
                        n_fail++;
                    end
                    if (m_tlast !== want.last) begin
                        $error("last_of_text: expected %b, got %b", want.last, m_tlast);
                        n_fail++;
                    end
                    if (m_tdata[39:33] !== 7'd0) begin
                        $error("tdata padding: expected %h, got %h", 7'd0, m_tdata[39:33]);
                        n_fail++;
                    end
                end
            end
        end
    end

    // receiver: random stall bursts plus one long hold on request
    initial begin : sink_ctrl
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            if (sink_hold_req > 0) begin
                stall_left    = sink_hold_req;
                sink_hold_req = 0;
            end else if (stall_left == 0 && sink_idle_on && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(1, 12);
            end
            if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        #4000000;
        $display("CHECKS FAILED");
        $finish;
    end

    task automatic send_cp(input logic [20:0] cp, input bit eot);
        if (src_idle_on && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, cp};
        s_tlast  <= eot;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic drain_results(input int limit);
        int waited;
        waited = 0;
        s_tvalid <= 1'b0;
        while (expected_chars.size() != 0 && waited < limit) begin
            @(posedge aclk);
            waited++;
        end
    endtask

    function automatic logic [20:0] random_code_point();
        case ($urandom_range(0, 9))
            0: return 21'($urandom_range(32'h0FF66, 32'h0FF9D));
            1: return $urandom_range(0, 1) ? ktn_pkg::HALF_VOICED : ktn_pkg::HALF_SEMI;
            2: return $urandom_range(0, 1) ? ktn_pkg::MARK_VOICED : ktn_pkg::MARK_SEMI;
            3: return 21'($urandom_range(32'h0FF60, 32'h0FF65));
            4: return 21'($urandom_range(32'h030A0, 32'h030F7));
            5: return 21'($urandom_range(32'h03040, 32'h0309F));
            6: return {5'd0, voice_bases[$urandom_range(0, 20)]};
            7: return {5'd0, voice_bases[$urandom_range(0, 20)]} + 21'h00060;
            default: return 21'($urandom & 32'h1FFFFF);
        endcase
    endfunction

    function automatic logic [20:0] random_mark();
        case ($urandom_range(0, 3))
            0: return ktn_pkg::MARK_VOICED;
            1: return ktn_pkg::MARK_SEMI;
            2: return ktn_pkg::HALF_VOICED;
            default: return ktn_pkg::HALF_SEMI;
        endcase
    endfunction

    // well-formed texts lean on base kana followed by a mark
    task automatic send_random_text(input bit well_formed, inout int sent);
        int          len;
        int          i;
        logic [20:0] base;
        len = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 16);
        for (i = 0; i < len; i++) begin
            if (well_formed && $urandom_range(0, 9) < 4) begin
                case ($urandom_range(0, 3))
                    0: base = {5'd0, semi_bases[$urandom_range(0, 4)]};
                    1: base = {5'd0, voice_bases[$urandom_range(0, 20)]};
                    2: base = {5'd0, voice_bases[$urandom_range(0, 20)]} + 21'h00060;
                    default: base = 21'($urandom_range(32'h0FF76, 32'h0FF8E));
                endcase
                send_cp(base, 1'b0);
                send_cp(random_mark(), i == len - 1);
                sent += 2;
            end else begin
                send_cp(well_formed ? random_code_point()
                                    : ($urandom_range(0, 2) == 0 ? random_mark()
                                                                 : random_code_point()),
                        i == len - 1);
                sent++;
            end
        end
    endtask

    task automatic test_directed();
        send_cp(21'h000000, 1'b1);             // zero, one-char text
        send_cp(21'h1FFFFF, 1'b1);             // all ones
        send_cp(ktn_pkg::MARK_VOICED, 1'b1);   // mark with nothing held
        send_cp(ktn_pkg::HALF_SEMI, 1'b0);
        send_cp(ktn_pkg::HALF_KANA_LO, 1'b0);
        send_cp(ktn_pkg::HALF_KANA_HI, 1'b0);
        send_cp(ktn_pkg::HALF_STOP, 1'b0);
        send_cp(ktn_pkg::HALF_COMMA, 1'b0);
        send_cp(ktn_pkg::HALF_MIDDOT, 1'b1);
        send_cp(21'h0FF76, 1'b0);              // halfwidth ka + halfwidth voiced
        send_cp(ktn_pkg::HALF_VOICED, 1'b0);
        send_cp(21'h030A6, 1'b0);              // katakana u + voiced
        send_cp(ktn_pkg::MARK_VOICED, 1'b0);
        send_cp(21'h03042, 1'b0);              // mark after a non-base
        send_cp(ktn_pkg::MARK_VOICED, 1'b0);
        send_cp(21'h0304B, 1'b0);              // semi mark on a voice-only base
        send_cp(ktn_pkg::MARK_SEMI, 1'b0);
        send_cp(21'h1304B, 1'b0);              // base code with high bits set
        send_cp(ktn_pkg::MARK_VOICED, 1'b0);
        send_cp(21'h030A0, 1'b0);
        send_cp(ktn_pkg::KATA_LO, 1'b0);
        send_cp(ktn_pkg::KATA_HI, 1'b0);
        send_cp(21'h030F7, 1'b0);
        send_cp(21'h00D800, 1'b0);             // surrogate
        send_cp(21'h110000, 1'b0);             // above the code space
        send_cp(21'h0FF8A, 1'b0);              // merge on the end-of-text beat
        send_cp(ktn_pkg::HALF_SEMI, 1'b1);
    endtask

    // index runs past eight bits within one text
    task automatic test_long_text();
        int i;
        for (i = 0; i < LONG_TEXT; i++)
            send_cp(($urandom_range(0, 3) == 0) ? random_mark() : random_code_point(), 1'b0);
        send_cp(21'h0306F, 1'b0);
        send_cp(ktn_pkg::MARK_SEMI, 1'b1);
    endtask

    task automatic test_backpressure();
        int i;
        src_idle_on   = 1'b0;
        sink_hold_req = 200;
        for (i = 0; i < 40; i++)
            send_cp(random_code_point(), i == 39);
        // a character stays held across this pause
        for (i = 0; i < 9; i++)
            send_cp(random_code_point(), 1'b0);
        send_cp(21'h03075, 1'b0);
        drain_results(20000);
        send_cp(ktn_pkg::HALF_SEMI, 1'b0);
        send_cp(21'h03042, 1'b1);
    endtask

    task automatic test_random();
        int sent;
        sent         = 0;
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
        while (sent < RANDOM_BEATS) begin
            if (sent >= RANDOM_BEATS - QUIET_TAIL) begin
                src_idle_on  = 1'b0;
                sink_idle_on = 1'b0;
            end
            send_random_text($urandom_range(0, 3) != 0, sent);
        end
    endtask

    initial begin : main
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
        test_long_text();
        test_backpressure();
        test_random();
        drain_results(5000);
        repeat (8) @(posedge aclk);
        if (expected_chars.size() != 0) begin
            $error("%0d expected results never arrived", expected_chars.size());
            n_fail++;
        end
        $display("sent %0d code points in %0d texts, checked %0d results, %0d mark merges",
                 n_beats, n_texts, n_results, n_merges);
        $display("covered halfwidth folding, katakana shift, long texts, stalls");
        if (n_fail == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

FILE: files.f
+incdir+rtl/core
rtl/core/ktn_pkg.sv
rtl/core/ktn_front.sv
rtl/core/ktn_queue.sv
rtl/core/ktn_back.sv
rtl/core/kana_text_normalizer.sv
tb/sv/tb_kana_text_normalizer.sv
